// File: rtl/scsg_pkg.sv
package scsg_pkg;

  // Event opcodes
  localparam logic [1:0] OP_FAST = 2'd0;
  localparam logic [1:0] OP_SLOW = 2'd1;
  localparam logic [1:0] OP_BTN  = 2'd2;

  // Latched button codes
  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_MODE = 2'd2;
  localparam logic [1:0] BTN_NONE = 2'd3;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [15:0] SUB_MAX   = 16'hFFFF;
  localparam logic [15:0] THR_RESET = 16'd1000;
  localparam logic [7:0]  SEG_DOT   = 8'h80;

  // One event request
  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] buttons;
  } ev_t;

  // Time of day and adjust mode
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic       mode;
  } time_t;

  // Four display patterns
  typedef struct packed {
    logic [7:0] min_ones;
    logic [7:0] min_tens;
    logic [7:0] hr_ones;
    logic [7:0] hr_tens;
  } seg_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Split a value of 0..59 into decimal digits
  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t d;
    logic [5:0] rest;
    d = '0;
    rest = v;
    if (v >= 6'd50) begin
      d.tens = 3'd5;
      rest = v - 6'd50;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
      rest = v - 6'd40;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
      rest = v - 6'd30;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
      rest = v - 6'd20;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
      rest = v - 6'd10;
    end
    d.ones = rest[3:0];
    return d;
  endfunction

  // Seven-segment pattern of one digit, no dot
  function automatic logic [7:0] seg_plain(input logic [3:0] digit);
    logic [7:0] p;
    p = 8'h00;
    case (digit)
      4'd0: p = 8'h3F;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5B;
      4'd3: p = 8'h4F;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6D;
      4'd6: p = 8'h7D;
      4'd7: p = 8'h07;
      4'd8: p = 8'h7F;
      4'd9: p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/scsg_core.sv
module scsg_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 thr_wr,
  input  logic [15:0]          thr_data,
  input  logic                 step,
  input  scsg_pkg::ev_t        ev,
  output scsg_pkg::time_t      time_nxt
);

  logic [15:0] thr_r;
  logic [15:0] sub_r, sub_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic        mode_r, mode_nxt;
  logic [1:0]  held_r, held_nxt;

  // Tick threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= scsg_pkg::THR_RESET;
    end else if (thr_wr) begin
      thr_r <= thr_data;
    end
  end

  // Event decode, button action, then normalisation
  always_comb begin
    sub_nxt  = sub_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    mode_nxt = mode_r;
    held_nxt = held_r;

    unique case (ev.opcode)
      scsg_pkg::OP_FAST: begin
        if (sub_r != scsg_pkg::SUB_MAX) sub_nxt = sub_r + 16'd1;
      end
      scsg_pkg::OP_SLOW: begin
        if (sub_r > thr_r) begin
          sec_nxt = sec_r + 6'd1;
          sub_nxt = '0;
        end
      end
      scsg_pkg::OP_BTN: begin
        if (held_r == scsg_pkg::BTN_NONE) begin
          // lowest-numbered pressed button wins (active low)
          if (!ev.buttons[0])      held_nxt = scsg_pkg::BTN_UP;
          else if (!ev.buttons[1]) held_nxt = scsg_pkg::BTN_DOWN;
          else if (!ev.buttons[2]) held_nxt = scsg_pkg::BTN_MODE;
        end else if (ev.buttons[held_r]) begin
          // released: act once
          held_nxt = scsg_pkg::BTN_NONE;
          unique case (held_r)
            scsg_pkg::BTN_UP: begin
              if (mode_r) hour_nxt = hour_r + 5'd1;
              else        min_nxt  = min_r + 6'd1;
            end
            scsg_pkg::BTN_DOWN: begin
              if (mode_r) begin
                if (hour_r != '0) hour_nxt = hour_r - 5'd1;
              end else begin
                if (min_r != '0) min_nxt = min_r - 6'd1;
              end
            end
            scsg_pkg::BTN_MODE: mode_nxt = ~mode_r;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // carries and day wrap
    if (sec_nxt > scsg_pkg::SEC_MAX) begin
      sec_nxt = '0;
      min_nxt = min_nxt + 6'd1;
    end
    if (min_nxt > scsg_pkg::MIN_MAX) begin
      min_nxt  = '0;
      hour_nxt = hour_nxt + 5'd1;
    end
    if (hour_nxt > scsg_pkg::HOUR_MAX) begin
      hour_nxt = '0;
      min_nxt  = '0;
      sec_nxt  = '0;
    end
  end

  // Clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= '0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      mode_r <= 1'b0;
      held_r <= scsg_pkg::BTN_NONE;
    end else if (step) begin
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

  assign time_nxt = '{sec: sec_nxt, min: min_nxt, hour: hour_nxt, mode: mode_nxt};

  // Checks
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (sec_r <= scsg_pkg::SEC_MAX) && (min_r <= scsg_pkg::MIN_MAX) &&
             (hour_r <= scsg_pkg::HOUR_MAX))
    else $error("time left its range");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(sub_r) && $stable(sec_r) && $stable(min_r) &&
              $stable(hour_r) && $stable(mode_r) && $stable(held_r))
    else $error("state moved without an event");

  a_mode_only_btn: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev.opcode != scsg_pkg::OP_BTN) |=> $stable(mode_r) && $stable(held_r))
    else $error("mode or held button changed on a tick");

  a_fast_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev.opcode == scsg_pkg::OP_FAST) && (sub_r != scsg_pkg::SUB_MAX)
    |=> sub_r == $past(sub_r) + 16'd1)
    else $error("fast tick did not count");

endmodule

// File: rtl/scsg_seg.sv
module scsg_seg (
  input  scsg_pkg::time_t  t,
  output scsg_pkg::seg_t   seg
);

  scsg_pkg::digits_t min_d;
  scsg_pkg::digits_t hr_d;

  // Decimal split of minutes and hours
  always_comb begin
    min_d = scsg_pkg::split_digits(t.min);
    hr_d  = scsg_pkg::split_digits({1'b0, t.hour});
  end

  // Pattern lookup, dot on the hour ones digit
  always_comb begin
    seg.min_ones = scsg_pkg::seg_plain(min_d.ones);
    seg.min_tens = scsg_pkg::seg_plain({1'b0, min_d.tens});
    seg.hr_ones  = scsg_pkg::seg_plain(hr_d.ones) | scsg_pkg::SEG_DOT;
    seg.hr_tens  = scsg_pkg::seg_plain({1'b0, hr_d.tens});
  end

endmodule

// File: rtl/settable_clock_with_segment_out.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// in        | in_valid / in_stall   | in_opcode, in_buttons
// out       | out_valid / out_stall | out_seconds .. out_seg_hr_tens
// cfg       | cfg_wr_en             | cfg_wr_data (tick threshold)
//
// A request is caught in the input register at its accepting edge and passes through the
// clock update and segment decode into the result register at the first edge that finds
// the result register free, where its result is offered. One request is accepted per
// cycle while the result side keeps up. in_stall rises only when the input register is
// full and the result register is held by out_stall. Synchronous active-low reset clears
// the time to 00:00:00, minutes mode, no button held, threshold 1000.
module settable_clock_with_segment_out (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_buttons,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_seconds,
  output logic [5:0]  out_minutes,
  output logic [4:0]  out_hours,
  output logic        out_set_mode,
  output logic [7:0]  out_seg_min_ones,
  output logic [7:0]  out_seg_min_tens,
  output logic [7:0]  out_seg_hr_ones,
  output logic [7:0]  out_seg_hr_tens,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic              ev_valid_r, ev_valid_nxt;
  scsg_pkg::ev_t     ev_r;
  logic              out_valid_r, out_valid_nxt;
  scsg_pkg::time_t   time_r;
  scsg_pkg::seg_t    seg_r;
  scsg_pkg::time_t   time_nxt;
  scsg_pkg::seg_t    seg_nxt;
  logic              out_free;
  logic              step;
  logic              in_take;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign step     = ev_valid_r && out_free;
  assign in_stall = ev_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    ev_valid_nxt = ev_valid_r;
    if (in_take)   ev_valid_nxt = 1'b1;
    else if (step) ev_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (step)          out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_r <= '{opcode: in_opcode, buttons: in_buttons};
    end
  end

  scsg_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr_wr   (cfg_wr_en),
    .thr_data (cfg_wr_data),
    .step     (step),
    .ev       (ev_r),
    .time_nxt (time_nxt)
  );

  scsg_seg u_seg (
    .t   (time_nxt),
    .seg (seg_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (step) begin
      time_r <= time_nxt;
      seg_r  <= seg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seconds      = time_r.sec;
  assign out_minutes      = time_r.min;
  assign out_hours        = time_r.hour;
  assign out_set_mode     = time_r.mode;
  assign out_seg_min_ones = seg_r.min_ones;
  assign out_seg_min_tens = seg_r.min_tens;
  assign out_seg_hr_ones  = seg_r.hr_ones;
  assign out_seg_hr_tens  = seg_r.hr_tens;

endmodule

// File: tb/sv/settable_clock_with_segment_out_tb.sv
`timescale 1ns / 1ps

module settable_clock_with_segment_out_tb;

  // Opcode the block leaves unused
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 60;

  // Expected view of the clock after one request
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic       mode;
    logic [7:0] min_ones;
    logic [7:0] min_tens;
    logic [7:0] hr_ones;
    logic [7:0] hr_tens;
  } clock_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = scsg_pkg::OP_FAST;
  logic [2:0]  in_buttons = 3'b111;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_seconds;
  logic [5:0]  out_minutes;
  logic [4:0]  out_hours;
  logic        out_set_mode;
  logic [7:0]  out_seg_min_ones;
  logic [7:0]  out_seg_min_tens;
  logic [7:0]  out_seg_hr_ones;
  logic [7:0]  out_seg_hr_tens;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  settable_clock_with_segment_out u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_buttons       (in_buttons),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seconds      (out_seconds),
    .out_minutes      (out_minutes),
    .out_hours        (out_hours),
    .out_set_mode     (out_set_mode),
    .out_seg_min_ones (out_seg_min_ones),
    .out_seg_min_tens (out_seg_min_tens),
    .out_seg_hr_ones  (out_seg_hr_ones),
    .out_seg_hr_tens  (out_seg_hr_tens),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #6 clk = ~clk;

  scsg_pkg::ev_t pending_events[$];
  clock_view_t   expected_views[$];

  int n_queued = 0;
  int n_accepted = 0;
  int results_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  int backpressure_cycles = 0;
  int thresholds_used = 0;

  // Idling controls, set per phase
  logic quiet = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_asked = 0;
  int   hold_served = 0;

  // Predicted state of the clock
  logic [15:0] thr_m = scsg_pkg::THR_RESET;
  logic [15:0] subsec_m = '0;
  logic [5:0]  sec_m = '0;
  logic [5:0]  min_m = '0;
  logic [4:0]  hour_m = '0;
  logic        mode_m = 1'b0;
  logic [1:0]  latched_m = scsg_pkg::BTN_NONE;
  int          sec_carries = 0;
  int          day_rollovers = 0;

  logic req_taken = 1'b0;

  function automatic logic [7:0] glyph(input int d);
    logic [7:0] g;
    case (d)
      0: g = 8'h3F;
      1: g = 8'h06;
      2: g = 8'h5B;
      3: g = 8'h4F;
      4: g = 8'h66;
      5: g = 8'h6D;
      6: g = 8'h7D;
      7: g = 8'h07;
      8: g = 8'h7F;
      default: g = 8'h6F;
    endcase
    return g;
  endfunction

  // Apply one request to the predicted clock and form the expected view
  task automatic advance_time(input scsg_pkg::ev_t ev, output clock_view_t v);
    case (ev.opcode)
      scsg_pkg::OP_FAST: if (subsec_m != scsg_pkg::SUB_MAX) subsec_m = subsec_m + 16'd1;
      scsg_pkg::OP_SLOW: begin
        if (subsec_m > thr_m) begin
          sec_m = sec_m + 6'd1;
          subsec_m = '0;
        end
      end
      scsg_pkg::OP_BTN: begin
        if (latched_m == scsg_pkg::BTN_NONE) begin
          if (!ev.buttons[0]) latched_m = scsg_pkg::BTN_UP;
          else if (!ev.buttons[1]) latched_m = scsg_pkg::BTN_DOWN;
          else if (!ev.buttons[2]) latched_m = scsg_pkg::BTN_MODE;
        end else if (ev.buttons[latched_m]) begin
          // released: the latched button acts now
          case (latched_m)
            scsg_pkg::BTN_UP: begin
              if (mode_m) hour_m = hour_m + 5'd1;
              else min_m = min_m + 6'd1;
            end
            scsg_pkg::BTN_DOWN: begin
              if (mode_m) begin
                if (hour_m != 0) hour_m = hour_m - 5'd1;
              end else if (min_m != 0) begin
                min_m = min_m - 6'd1;
              end
            end
            default: mode_m = ~mode_m;
          endcase
          latched_m = scsg_pkg::BTN_NONE;
        end
      end
      default: ;
    endcase
    // normalise
    if (sec_m > scsg_pkg::SEC_MAX) begin
      sec_m = '0;
      min_m = min_m + 6'd1;
      sec_carries++;
    end
    if (min_m > scsg_pkg::MIN_MAX) begin
      min_m = '0;
      hour_m = hour_m + 5'd1;
    end
    if (hour_m > scsg_pkg::HOUR_MAX) begin
      hour_m = '0;
      min_m = '0;
      sec_m = '0;
      day_rollovers++;
    end
    v.sec = sec_m;
    v.min = min_m;
    v.hour = hour_m;
    v.mode = mode_m;
    v.min_ones = glyph(min_m % 10);
    v.min_tens = glyph(min_m / 10);
    v.hr_ones = glyph(hour_m % 10) | scsg_pkg::SEG_DOT;
    v.hr_tens = glyph(hour_m / 10);
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Driver: offers the next pending request at the falling edge
  always @(negedge clk) begin : driver
    scsg_pkg::ev_t nxt;
    int  send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0 && !quiet) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        nxt = pending_events.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.opcode;
        in_buttons <= nxt.buttons;
        send_gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stalls: random bursts, plus a long hold on request
  always @(negedge clk) begin : receiver
    int hold_left;
    int stall_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks results, then predicts for each accepted request
  always @(posedge clk) begin : monitor
    clock_view_t   want;
    scsg_pkg::ev_t ev;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          flag_mismatch("result with no request outstanding", 1, 0);
        end else begin
          want = expected_views.pop_front();
          results_checked++;
          if (out_seconds !== want.sec) flag_mismatch("seconds", out_seconds, want.sec);
          if (out_minutes !== want.min) flag_mismatch("minutes", out_minutes, want.min);
          if (out_hours !== want.hour) flag_mismatch("hours", out_hours, want.hour);
          if (out_set_mode !== want.mode) flag_mismatch("set_mode", out_set_mode, want.mode);
          if (out_seg_min_ones !== want.min_ones)
            flag_mismatch("seg_min_ones", out_seg_min_ones, want.min_ones);
          if (out_seg_min_tens !== want.min_tens)
            flag_mismatch("seg_min_tens", out_seg_min_tens, want.min_tens);
          if (out_seg_hr_ones !== want.hr_ones)
            flag_mismatch("seg_hr_ones", out_seg_hr_ones, want.hr_ones);
          if (out_seg_hr_tens !== want.hr_tens)
            flag_mismatch("seg_hr_tens", out_seg_hr_tens, want.hr_tens);
        end
      end
      if (in_valid && in_stall) backpressure_cycles++;
      if (cfg_wr_en) thr_m = cfg_wr_data;
      if (in_valid && !in_stall) begin
        ev.opcode = in_opcode;
        ev.buttons = in_buttons;
        advance_time(ev, want);
        expected_views.push_back(want);
        n_accepted++;
      end
    end
    req_taken <= rst_n && in_valid && !in_stall;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d requests still outstanding",
               cycle_count, n_queued - results_checked);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_event(input logic [1:0] op, input logic [2:0] lv);
    scsg_pkg::ev_t e;
    e.opcode = op;
    e.buttons = lv;
    pending_events.push_back(e);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_views.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    thresholds_used++;
  endtask

  // Press and release of one button, with noise on the other levels
  task automatic queue_press(input logic [1:0] code, output int added);
    logic [2:0] lv;
    int holds;
    lv = 3'($urandom_range(0, 7));
    lv[code] = 1'b0;
    for (int b = 0; b < 3; b++) if (b < code) lv[b] = 1'b1;
    queue_event(scsg_pkg::OP_BTN, lv);
    holds = $urandom_range(0, 2);
    repeat (holds) begin
      lv = 3'($urandom_range(0, 7));
      lv[code] = 1'b0;
      queue_event(scsg_pkg::OP_BTN, lv);
    end
    lv = 3'($urandom_range(0, 7));
    lv[code] = 1'b1;
    queue_event(scsg_pkg::OP_BTN, lv);
    added = holds + 2;
  endtask

  // Mostly tick runs and clean button presses, some raw noise
  task automatic queue_mixed_traffic(input int count, input int thr_hint);
    int added;
    int r;
    int fast_n;
    int got;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 3) == 0) fast_n = $urandom_range(0, thr_hint);
        else fast_n = $urandom_range(thr_hint, thr_hint + 2);
        repeat (fast_n) queue_event(scsg_pkg::OP_FAST, 3'($urandom_range(0, 7)));
        queue_event(scsg_pkg::OP_SLOW, 3'($urandom_range(0, 7)));
        added += fast_n + 1;
      end else if (r < 87) begin
        r = $urandom_range(0, 9);
        if (r < 6) queue_press(scsg_pkg::BTN_UP, got);
        else if (r < 9) queue_press(scsg_pkg::BTN_DOWN, got);
        else queue_press(scsg_pkg::BTN_MODE, got);
        added += got;
      end else begin
        queue_event(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        added++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: unused opcode, ignored levels, latch order, clamps, mode toggle
    queue_event(OP_SPARE, 3'b000);
    queue_event(scsg_pkg::OP_FAST, 3'b000);
    queue_event(scsg_pkg::OP_SLOW, 3'b000);
    queue_event(scsg_pkg::OP_BTN, 3'b000);
    queue_event(scsg_pkg::OP_BTN, 3'b110);
    queue_event(scsg_pkg::OP_BTN, 3'b001);
    queue_event(scsg_pkg::OP_BTN, 3'b001);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b101);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b011);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b101);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b110);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b110);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b011);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(OP_SPARE, 3'b111);
    queue_event(scsg_pkg::OP_BTN, 3'b111);
    queue_event(scsg_pkg::OP_FAST, 3'b111);
    queue_event(scsg_pkg::OP_SLOW, 3'b111);

    // Lowest threshold, moderate idling on both sides
    write_threshold(16'd0);
    send_idle_pct = 15;
    recv_idle_pct = 15;
    queue_mixed_traffic(400, 1);

    // Result side held off while requests keep coming
    write_threshold(16'd3);
    send_idle_pct = 0;
    hold_asked++;
    queue_mixed_traffic(150, 4);

    // Heavy idling, small random threshold
    write_threshold(16'($urandom_range(0, 15)));
    send_idle_pct = 35;
    recv_idle_pct = 35;
    queue_mixed_traffic(300, 8);

    // Random full-range threshold; seconds mostly frozen
    write_threshold(16'($urandom_range(0, 65535)));
    send_idle_pct = 10;
    recv_idle_pct = 10;
    queue_mixed_traffic(100, 6);

    // Largest thresholds, no idling from here on
    quiet = 1'b1;
    write_threshold(16'hFFFF);
    repeat (4) queue_event(scsg_pkg::OP_FAST, 3'b111);
    queue_event(scsg_pkg::OP_SLOW, 3'b000);
    write_threshold(16'hFFFE);
    queue_event(scsg_pkg::OP_SLOW, 3'b111);
    queue_event(scsg_pkg::OP_FAST, 3'b010);
    queue_event(scsg_pkg::OP_SLOW, 3'b101);

    write_threshold(16'd1);
    queue_mixed_traffic(400, 2);
    wait_drained();

    if (expected_views.size() != 0) flag_mismatch("results never delivered",
                                                   0, expected_views.size());
    $display("Covered %0d requests, %0d results checked, %0d threshold settings incl. 0/FFFF",
             n_queued, results_checked, thresholds_used);
    $display("Saw %0d second carries, %0d day rollovers, %0d back-pressure cycles at input",
             sec_carries, day_rollovers, backpressure_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: settable_clock_with_segment_out.f
rtl/scsg_pkg.sv
rtl/scsg_core.sv
rtl/scsg_seg.sv
rtl/settable_clock_with_segment_out.sv
tb/sv/settable_clock_with_segment_out_tb.sv
